@@ hw/rtl/srrack_pkg.sv @@
// Package for the selective-repeat receiver acknowledgement block.
// Holds field widths, window limits and the run-of-ones counter.
// No dependencies.
package srrack_pkg;

   // Field widths
   localparam int SEQ_W     = 32;
   localparam int BITMAP_W  = 32;
   localparam int WIN_CFG_W = 6;

   // Window limits
   localparam int MAX_WINDOW = 32;
   localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = WIN_CFG_W'(32);

   // Counter width able to hold 0..BITMAP_W
   localparam int CNT_W     = $clog2(BITMAP_W + 1);
   localparam int BIT_IDX_W = $clog2(BITMAP_W);

   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   // Count the run of ones at the bottom of a bitmap (BITMAP_W when all set).
   // Isolate the lowest zero as a one-hot word, then encode it.
   function automatic logic [CNT_W-1:0] trailing_ones(input logic [BITMAP_W-1:0] bm);
      logic [BITMAP_W-1:0] onehot;
      logic [CNT_W-1:0]    idx;
      onehot = ~bm & (bm + {{(BITMAP_W-1){1'b0}}, 1'b1});
      idx    = '0;
      for (int i = 0; i < BITMAP_W; i++) begin
         if (onehot[i]) begin
            idx = idx | CNT_W'(i);
         end
      end
      if (onehot == '0) begin
         idx = CNT_W'(BITMAP_W);
      end
      return idx;
   endfunction

endpackage

@@ hw/rtl/selective_repeat_receiver_ack.sv @@
// Top level of the selective-repeat receiver acknowledgement block.
// Window state, input register, result handshake and window CSR.
// Depends on srrack_pkg.
//
// Usage:
//   req_*  : one beat per arriving segment (sequence number, final flag).
//   rsp_*  : one acknowledgement beat per segment: cumulative sequence
//            number, selective-ack bitmap and a transfer-done flag.
//   csr_*  : write of the receive window width; ready whenever the input
//            register is empty. Write only while the block is idle.
// Pipeline: an accepted segment passes two register stages, the input
// register, then the state/result registers, before its acknowledgement.
// Throughput: one segment per cycle unless rsp_stall holds a result; the window
// update, a 32-bit compare, a 32-bit add and a priority encode, is combinational.
// Reset: base 0, empty bitmap, no final segment known, window 32, both
// channels empty.
// Stall: while rsp_stall holds a result, the input register keeps its
// segment and req_stall rises once that register is full; the window state
// does not move until the held result is taken.
module selective_repeat_receiver_ack
   import srrack_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // segment input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [SEQ_W-1:0]     req_segment_seq,
   input  logic                 req_is_final,
   // acknowledgement output
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [SEQ_W-1:0]     rsp_ack_seq,
   output logic [BITMAP_W-1:0]  rsp_sack_bitmap,
   output logic                 rsp_transfer_done,
   // window configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [WIN_CFG_W-1:0] csr_window_size
);

   // Registers
   logic                 in_valid_ff,  in_valid_in;
   logic [SEQ_W-1:0]     in_seq_ff,    in_seq_in;
   logic                 in_final_ff,  in_final_in;
   logic [WIN_CFG_W-1:0] window_ff,    window_in;
   logic [SEQ_W-1:0]     expected_ff,  expected_in;
   logic [BITMAP_W-1:0]  bitmap_ff,    bitmap_in;
   logic [SEQ_W-1:0]     final_ff,     final_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 done_ff,      done_in;

   // Datapath signals
   logic                 out_free;
   logic                 load;
   logic                 req_take;
   logic [WIN_CFG_W-1:0] win_eff;
   logic [SEQ_W-1:0]     diff;
   logic                 seg_in_win;
   logic [CNT_W-1:0]     run_len;
   logic [SEQ_W:0]       next_wide;
   logic [SEQ_W-1:0]     diff_m1;
   logic [BIT_IDX_W-1:0] bit_idx;

   // Handshake: stage moves when the result slot is empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = !in_valid_ff;

   // Clamp the window width
   assign win_eff = (int'(window_ff) > MAX_WINDOW) ? WIN_CFG_W'(MAX_WINDOW) : window_ff;

   // Window test and offsets
   assign diff       = in_seq_ff - expected_ff;
   assign seg_in_win = (in_seq_ff >= expected_ff) && (diff < SEQ_W'(win_eff));
   assign diff_m1    = diff - SEQ_W'(1);
   assign bit_idx    = diff_m1[BIT_IDX_W-1:0];

   // Advance length for a segment at the base
   assign run_len   = trailing_ones(bitmap_ff);
   assign next_wide = {1'b0, expected_ff} + (SEQ_W+1)'(1) + (SEQ_W+1)'(run_len);

   // Next state of the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_seq_in   = in_seq_ff;
      in_final_in = in_final_ff;
      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_seq_in   = req_segment_seq;
         in_final_in = req_is_final;
      end
   end

   // Window update; the state registers double as the held result
   always_comb begin
      expected_in  = expected_ff;
      bitmap_in    = bitmap_ff;
      final_in     = final_ff;
      window_in    = window_ff;
      rsp_valid_in = rsp_valid_ff;
      done_in      = done_ff;
      if (csr_valid && csr_ready) begin
         window_in = csr_window_size;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         if (in_final_ff) begin
            final_in = in_seq_ff;
         end
         if (seg_in_win) begin
            if (diff == '0) begin
               expected_in = next_wide[SEQ_W] ? SEQ_MAX : next_wide[SEQ_W-1:0];
               bitmap_in   = (bitmap_ff >> run_len) >> 1;
            end else if (diff <= SEQ_W'(BITMAP_W)) begin
               bitmap_in = bitmap_ff | (BITMAP_W'(1) << bit_idx);
            end
         end
         done_in = final_in < expected_in;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
         expected_ff  <= '0;
         bitmap_ff    <= '0;
         final_ff     <= SEQ_MAX;
         done_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         expected_ff  <= expected_in;
         bitmap_ff    <= bitmap_in;
         final_ff     <= final_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      in_seq_ff   <= in_seq_in;
      in_final_ff <= in_final_in;
   end

   // Drive the result channel
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ack_seq       = expected_ff;
   assign rsp_sack_bitmap   = bitmap_ff;
   assign rsp_transfer_done = done_ff;

   // Checks
   a_base_monotonic : assert property (@(posedge clock) disable iff (reset)
      load |=> expected_ff >= $past(expected_ff))
      else $error("window base moved backward");

   a_state_holds : assert property (@(posedge clock) disable iff (reset)
      !load |=> ($stable(expected_ff) && $stable(bitmap_ff) && $stable(final_ff)))
      else $error("window state changed without a segment");

   a_done_matches : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (done_ff == (final_ff < expected_ff)))
      else $error("transfer-done flag disagrees with state");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled with a free stage");

   a_load_gives_result : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("segment processed without a result");

endmodule

@@ tb/tb_selective_repeat_receiver_ack.sv @@
// Self-checking testbench for the selective-repeat receiver ack block.
// Predicts each acknowledgement beat from a local window model; needs srrack_pkg
// and the selective_repeat_receiver_ack RTL.
module tb_selective_repeat_receiver_ack;
   import srrack_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 180;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic             fin;
   } segment_type;

   typedef struct packed {
      logic [SEQ_W-1:0]    ack_seq;
      logic [BITMAP_W-1:0] sack_bitmap;
      logic                transfer_done;
   } ack_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [SEQ_W-1:0]     req_segment_seq = '0;
   logic                 req_is_final = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SEQ_W-1:0]     rsp_ack_seq;
   logic [BITMAP_W-1:0]  rsp_sack_bitmap;
   logic                 rsp_transfer_done;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [WIN_CFG_W-1:0] csr_window_size = WINDOW_RESET;

   // segments waiting for the driver, acks waiting for the monitor
   segment_type  seg_queue[$];
   ack_beat_type ack_queue[$];

   // window model
   logic [SEQ_W-1:0]     base_pred;
   logic [BITMAP_W-1:0]  sack_pred;
   logic [SEQ_W-1:0]     last_seg_pred;
   logic [WIN_CFG_W-1:0] window_pred;

   logic         idle_en = 1'b1;
   int unsigned  req_gap = 0;
   int unsigned  stall_left = 0;
   int unsigned  segs_accepted = 0;
   int unsigned  acks_seen = 0;
   int unsigned  done_seen = 0;
   int unsigned  mismatches = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  windows_run = 0;
   segment_type  next_seg;
   ack_beat_type exp_ack;

   selective_repeat_receiver_ack u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_segment_seq   (req_segment_seq),
      .req_is_final      (req_is_final),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ack_seq       (rsp_ack_seq),
      .rsp_sack_bitmap   (rsp_sack_bitmap),
      .rsp_transfer_done (rsp_transfer_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_size   (csr_window_size)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advance the window model by one segment and queue the segment and its ack.
   task automatic push_segment(input logic [SEQ_W-1:0] seq, input logic fin);
      int unsigned      eff;
      int unsigned      run;
      logic [SEQ_W:0]   limit_seq;
      logic [SEQ_W:0]   next_base;
      logic [SEQ_W-1:0] offset;
      ack_beat_type     beat;
      segment_type      item;
      eff = (window_pred > MAX_WINDOW) ? MAX_WINDOW : window_pred;
      if (fin) begin
         last_seg_pred = seq;
      end
      limit_seq = {1'b0, base_pred} + (SEQ_W+1)'(eff);
      if (seq >= base_pred && {1'b0, seq} < limit_seq) begin
         offset = seq - base_pred;
         if (offset == '0) begin
            // slide past the base and the run of buffered segments behind it
            run = 0;
            while (run < BITMAP_W && sack_pred[run]) begin
               run++;
            end
            next_base = {1'b0, base_pred} + (SEQ_W+1)'(run + 1);
            base_pred = (next_base > {1'b0, SEQ_MAX}) ? SEQ_MAX : next_base[SEQ_W-1:0];
            sack_pred = (run + 1 >= BITMAP_W) ? '0 : (sack_pred >> (run + 1));
         end else if ((offset - 1) < BITMAP_W) begin
            sack_pred[offset - 1] = 1'b1;
         end
      end
      beat.ack_seq       = base_pred;
      beat.sack_bitmap   = sack_pred;
      beat.transfer_done = (last_seg_pred < base_pred);
      item.seq = seq;
      item.fin = fin;
      ack_queue.push_back(beat);
      seg_queue.push_back(item);
   endtask

   // Wait until every queued segment has been acknowledged, then settle.
   task automatic wait_idle();
      while (seg_queue.size() != 0 || ack_queue.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the window register while the block is idle.
   task automatic write_window(input logic [WIN_CFG_W-1:0] w);
      wait_idle();
      csr_valid       <= 1'b1;
      csr_window_size <= w;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid   <= 1'b0;
      window_pred = w;
      windows_run++;
   endtask

   // Random segments, mostly near the base so the window keeps moving.
   task automatic push_random(input int unsigned count);
      int unsigned made;
      int unsigned eff;
      int unsigned pick;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] start;
      made = 0;
      while (made < count) begin
         eff = (window_pred > MAX_WINDOW) ? MAX_WINDOW : window_pred;
         pick = $urandom_range(0, 99);
         if (pick < 8 && eff > 1) begin
            // fill the window top down, then close the gap at the base
            start = base_pred;
            for (int off = eff - 1; off >= 1; off--) begin
               push_segment(start + SEQ_W'(off), 1'b0);
            end
            push_segment(start, 1'b0);
            made += eff;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               seq = base_pred;
            end else if (pick < 65) begin
               seq = base_pred + SEQ_W'($urandom_range(1, eff + 2));
            end else if (pick < 75) begin
               seq = (base_pred > 40) ? base_pred - SEQ_W'($urandom_range(1, 40))
                                      : SEQ_W'($urandom_range(0, 40));
            end else if (pick < 90) begin
               seq = $urandom;
            end else begin
               seq = SEQ_MAX - SEQ_W'($urandom_range(0, 3));
            end
            push_segment(seq, ($urandom_range(0, 15) == 0));
            made++;
         end
      end
   endtask

   // Drive segment beats; hold the payload while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            segs_accepted++;
         end
         if (req_gap != 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (seg_queue.size() != 0 && idle_en && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 4);
            req_valid <= 1'b0;
         end else if (seg_queue.size() != 0) begin
            next_seg = seg_queue.pop_front();
            req_valid       <= 1'b1;
            req_segment_seq <= next_seg.seq;
            req_is_final    <= next_seg.fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Check ack beats against the oldest prediction; stall in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            acks_seen++;
            if (rsp_transfer_done) begin
               done_seen++;
            end
            if (ack_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected ack beat: ack_seq=%0d sack=%h done=%0b",
                           rsp_ack_seq, rsp_sack_bitmap, rsp_transfer_done);
               end
            end else begin
               exp_ack = ack_queue.pop_front();
               if (rsp_ack_seq !== exp_ack.ack_seq ||
                   rsp_sack_bitmap !== exp_ack.sack_bitmap ||
                   rsp_transfer_done !== exp_ack.transfer_done) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ack %0d mismatch: ack_seq exp %0d got %0d, sack exp %h got %h,",
                              acks_seen, exp_ack.ack_seq, rsp_ack_seq,
                              exp_ack.sack_bitmap, rsp_sack_bitmap);
                     $display("   done exp %0b got %0b",
                              exp_ack.transfer_done, rsp_transfer_done);
                  end
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Abort when no beat of any kind moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic [WIN_CFG_W-1:0] windows[PHASES];
      base_pred     = '0;
      sack_pred     = '0;
      last_seg_pred = SEQ_MAX;
      window_pred   = WINDOW_RESET;
      windows = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd5, 6'd31, 6'd33,
                  WIN_CFG_W'($urandom_range(1, 32)), WIN_CFG_W'($urandom_range(0, 63)),
                  6'd32};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: base moves, buffered runs, window edges, final markers
      push_segment(32'd0, 1'b0);
      push_segment(32'd3, 1'b0);
      push_segment(32'd2, 1'b0);
      push_segment(32'd1, 1'b0);
      push_segment(32'd35, 1'b0);
      push_segment(32'd36, 1'b0);
      push_segment(32'd0, 1'b0);
      push_segment(SEQ_MAX, 1'b1);
      push_segment(SEQ_MAX, 1'b0);
      push_segment(32'd5, 1'b1);
      push_segment(32'd4, 1'b0);
      push_segment(32'd5, 1'b0);
      push_segment(32'd6, 1'b0);
      push_segment(32'h8000_0000, 1'b0);
      push_segment(32'd8, 1'b0);
      push_segment(32'd9, 1'b0);
      push_segment(32'd10, 1'b0);
      push_segment(32'd7, 1'b0);
      push_segment(32'd2, 1'b1);
      push_segment(32'h5555_5555, 1'b0);
      push_segment(32'hAAAA_AAAA, 1'b1);

      // random phases, one window setting each; the last runs without idling
      for (int p = 0; p < PHASES; p++) begin
         write_window(windows[p]);
         if (p == PHASES - 1) begin
            idle_en <= 1'b0;
         end
         push_random(ITEMS_PER_PHASE);
      end

      wait_idle();
      $display("Covered %0d segments and %0d acks over %0d window settings.",
               segs_accepted, acks_seen, windows_run);
      $display("Base ended at %0d; %0d acks reported the transfer as done.",
               base_pred, done_seen);
      if (mismatches == 0 && ack_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
